// ===== rtl/lattice_pair_energy_lookup_core_assert.svh =====
// ----------------------------------------------------------------------------
// lattice pair energy lookup assertion macros
// concurrent checks with same-cycle and next-cycle consequents
// ----------------------------------------------------------------------------
`ifndef LATTICE_PAIR_ENERGY_LOOKUP_CORE_ASSERT_SVH
`define LATTICE_PAIR_ENERGY_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define LPEL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPEL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpel_pkg.sv =====
// ----------------------------------------------------------------------------
// lpel_pkg
// shared constants and item control types of the pair energy lookup
// ----------------------------------------------------------------------------
package lpel_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COORD_BITS_DEF  = 13;
    localparam int SUM_BITS_DEF    = 48;

    localparam int IDX_BITS    = 12;
    localparam int VALUE_BITS  = 32;
    localparam int CUTOFF_BITS = 12;

    typedef enum logic {
        REQ_TABLE_WRITE = 1'b0,
        REQ_NEIGHBOR    = 1'b1
    } req_type_t;

    typedef struct packed {
        logic                         valid;
        req_type_t                    kind;
        logic                         nb_valid;
        logic                         last;
        logic [IDX_BITS-1:0]          idx;
        logic signed [VALUE_BITS-1:0] value;
    } ctl_t;

endpackage

// ===== rtl/lpel_if.sv =====
// ----------------------------------------------------------------------------
// lpel stream interfaces
// request channel (table writes and neighbor slots) and result channel
// ----------------------------------------------------------------------------
interface lpel_in_if #(
    parameter int COORD_BITS = lpel_pkg::COORD_BITS_DEF
);
    import lpel_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [IDX_BITS-1:0]           table_index;
    logic signed [VALUE_BITS-1:0]  table_value;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;
    logic signed [COORD_BITS-1:0]  nb_x;
    logic signed [COORD_BITS-1:0]  nb_y;
    logic signed [COORD_BITS-1:0]  nb_z;
    logic                          nb_valid;
    logic                          last;

    modport source (
        output valid, req_type, table_index, table_value,
        output point_x, point_y, point_z, nb_x, nb_y, nb_z, nb_valid, last,
        input  ready
    );

    modport sink (
        input  valid, req_type, table_index, table_value,
        input  point_x, point_y, point_z, nb_x, nb_y, nb_z, nb_valid, last,
        output ready
    );
endinterface

interface lpel_out_if #(
    parameter int SUM_BITS = lpel_pkg::SUM_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [SUM_BITS-1:0]  energy_sum;
    logic                        saturated;

    modport source (
        output valid, energy_sum, saturated,
        input  ready
    );

    modport sink (
        input  valid, energy_sum, saturated,
        output ready
    );
endinterface

// ===== rtl/lpel_dist.sv =====
// ----------------------------------------------------------------------------
// lpel_dist
// two-stage squared lattice distance: coordinate differences, then squares;
// the three squares are summed on the output
// ----------------------------------------------------------------------------
module lpel_dist #(
    parameter int COORD_BITS = lpel_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         enable,
    input  lpel_pkg::ctl_t               item,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic signed [COORD_BITS-1:0] nb_x,
    input  logic signed [COORD_BITS-1:0] nb_y,
    input  logic signed [COORD_BITS-1:0] nb_z,
    output lpel_pkg::ctl_t               stage_item,
    output logic [2*COORD_BITS+2:0]      dist_sq
);
    import lpel_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS + 1;
    localparam int R2W = 2 * COORD_BITS + 3;

    ctl_t                 s1_item_reg;
    ctl_t                 s2_item_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dz_reg;
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dy_next;
    logic signed [DW-1:0] dz_next;
    logic [SQW-1:0]       sqx_reg;
    logic [SQW-1:0]       sqy_reg;
    logic [SQW-1:0]       sqz_reg;
    logic signed [2*DW-1:0] prod_x;
    logic signed [2*DW-1:0] prod_y;
    logic signed [2*DW-1:0] prod_z;

    assign dx_next = DW'(nb_x) - DW'(point_x);
    assign dy_next = DW'(nb_y) - DW'(point_y);
    assign dz_next = DW'(nb_z) - DW'(point_z);

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
            s2_item_reg <= '0;
        end
        else if (enable)
        begin
            s1_item_reg <= item;
            s2_item_reg <= s1_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            sqx_reg <= prod_x[SQW-1:0];
            sqy_reg <= prod_y[SQW-1:0];
            sqz_reg <= prod_z[SQW-1:0];
        end
    end

    assign stage_item = s2_item_reg;
    assign dist_sq    = R2W'(sqx_reg) + R2W'(sqy_reg) + R2W'(sqz_reg);

endmodule

// ===== rtl/lattice_pair_energy_lookup_core.sv =====
// ----------------------------------------------------------------------------
// lattice_pair_energy_lookup_core
// a closing neighbor slot passes the distance stages, lookup stage and result
// register before its sum shows; items enter one per cycle unless stalled:
// a result blocked at the output stalls the pipeline only when a second one
// is due; asynchronous active-low reset clears sum, flag, cutoff and valids
// ----------------------------------------------------------------------------
`include "lattice_pair_energy_lookup_core_assert.svh"

module lattice_pair_energy_lookup_core #(
    parameter int TABLE_DEPTH = lpel_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = lpel_pkg::COORD_BITS_DEF,
    parameter int SUM_BITS    = lpel_pkg::SUM_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpel_pkg::CUTOFF_BITS-1:0] cfg_wdata,
    lpel_in_if.sink                          req,
    lpel_out_if.source                       rsp
);
    import lpel_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int R2W  = 2 * COORD_BITS + 3;
    localparam int CMPW = (R2W > 17) ? R2W : 17;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic [CUTOFF_BITS-1:0] cutoff_reg;

    ctl_t           in_item;
    ctl_t           s3_item;
    logic [R2W-1:0] dist_sq;
    logic           adv;
    logic           stall;

    logic [CMPW-1:0] r2_c;
    logic [CMPW-1:0] idx_c;
    logic [CMPW-1:0] depth_c;
    logic [CMPW-1:0] cutoff_c;
    logic            hit;
    logic            mem_we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;

    logic signed [VALUE_BITS-1:0] energy_table_mem [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] mem_rdata_reg;

    ctl_t s4_ctl_reg;
    logic s4_hit_reg;
    logic s4_active;
    logic s4_emits;

    logic signed [SUM_BITS-1:0]   sum_reg;
    logic signed [SUM_BITS-1:0]   sum_next;
    logic                         clip_reg;
    logic                         clip_next;
    logic signed [VALUE_BITS-1:0] add_val;
    logic signed [SUM_BITS:0]     acc_wide;
    logic                         acc_ovf;
    logic signed [SUM_BITS-1:0]   acc_sum;
    logic                         acc_clip;

    logic                         out_valid_reg;
    logic signed [SUM_BITS-1:0]   out_sum_reg;
    logic                         out_sat_reg;

    // request transfer into the distance pipeline
    assign in_item = '{
        valid:    req.valid,
        kind:     req_type_t'(req.req_type),
        nb_valid: req.nb_valid,
        last:     req.last,
        idx:      req.table_index,
        value:    req.table_value
    };

    lpel_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (adv),
        .item       (in_item),
        .point_x    (req.point_x),
        .point_y    (req.point_y),
        .point_z    (req.point_z),
        .nb_x       (req.nb_x),
        .nb_y       (req.nb_y),
        .nb_z       (req.nb_z),
        .stage_item (s3_item),
        .dist_sq    (dist_sq)
    );

    // stall only when a result is due and the output register is still held
    assign s4_active = s4_ctl_reg.valid && (s4_ctl_reg.kind == REQ_NEIGHBOR);
    assign s4_emits  = s4_active && s4_ctl_reg.last;
    assign stall     = s4_emits && out_valid_reg && !rsp.ready;
    assign adv       = !stall;
    assign req.ready = adv;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
        end
        else if (cfg_we)
        begin
            cutoff_reg <= cfg_wdata;
        end
    end

    // table access stage
    assign r2_c     = CMPW'(dist_sq);
    assign idx_c    = CMPW'(s3_item.idx);
    assign depth_c  = CMPW'(TABLE_DEPTH);
    assign cutoff_c = CMPW'(cutoff_reg);
    assign waddr    = idx_c[AW-1:0];
    assign raddr    = r2_c[AW-1:0];
    assign mem_we   = s3_item.valid && (s3_item.kind == REQ_TABLE_WRITE) && (idx_c < depth_c);
    assign hit      = s3_item.nb_valid && (r2_c <= cutoff_c) && (r2_c < depth_c);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (mem_we)
            begin
                energy_table_mem[waddr] <= s3_item.value;
            end
            mem_rdata_reg <= energy_table_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg <= '0;
            s4_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_ctl_reg <= s3_item;
            s4_hit_reg <= hit;
        end
    end

    // saturating accumulate
    assign add_val  = s4_hit_reg ? mem_rdata_reg : '0;
    assign acc_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(add_val);
    assign acc_ovf  = acc_wide[SUM_BITS] != acc_wide[SUM_BITS-1];
    assign acc_sum  = acc_ovf ? (acc_wide[SUM_BITS] ? SUM_MIN : SUM_MAX)
                              : acc_wide[SUM_BITS-1:0];
    assign acc_clip = clip_reg || acc_ovf;

    always_comb
    begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (adv && s4_active)
        begin
            if (s4_ctl_reg.last)
            begin
                sum_next  = '0;
                clip_next = 1'b0;
            end
            else
            begin
                sum_next  = acc_sum;
                clip_next = acc_clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            clip_reg <= clip_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s4_emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s4_emits)
        begin
            out_sum_reg <= acc_sum;
            out_sat_reg <= acc_clip;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.energy_sum = out_sum_reg;
    assign rsp.saturated  = out_sat_reg;

    `LPEL_ASSERT_IMP(a_stall_needs_blocked_result, clk, rst_n, !req.ready,
        s4_emits && out_valid_reg, "request stalled without a blocked result")
    `LPEL_ASSERT_NXT(a_sum_cleared_on_close, clk, rst_n, adv && s4_emits,
        (sum_reg == '0) && !clip_reg, "running sum not cleared after closing slot")
    `LPEL_ASSERT_NXT(a_lookup_held_on_stall, clk, rst_n, stall,
        $stable(s4_ctl_reg) && $stable(s4_hit_reg), "lookup stage moved during stall")
    `LPEL_ASSERT_IMP(a_result_from_close, clk, rst_n, $rose(out_valid_reg),
        $past(s4_emits), "result appeared without a closing slot")

endmodule

// ===== tb/lpel_energy_checker.sv =====
// ----------------------------------------------------------------------------
// lpel_energy_checker
// watches the request and result channels of the pair energy lookup, keeps
// its own copy of the energy table, cutoff and saturating sum, and compares
// every result transfer against the oldest predicted query sum
// ----------------------------------------------------------------------------
module lpel_energy_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpel_pkg::CUTOFF_BITS-1:0] cfg_wdata,
    lpel_in_if                               req,
    lpel_out_if                              rsp,
    output int                               fail_count,
    output int                               pending,
    output int                               sums_seen,
    output int                               clips_seen
);
    import lpel_pkg::*;

    localparam longint SUM_MAX = (64'sd1 <<< (SUM_BITS_DEF - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic signed [SUM_BITS_DEF-1:0] energy_sum;
        logic                           saturated;
    } energy_result_t;

    logic signed [VALUE_BITS-1:0] energy_tab [TABLE_DEPTH_DEF];
    longint                       running_energy;
    logic                         energy_clipped;
    logic [CUTOFF_BITS-1:0]       cutoff_sq;
    energy_result_t               sums_due [$];

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        longint         dx;
        longint         dy;
        longint         dz;
        longint         r2;
        longint         next_sum;
        energy_result_t want;
        if (!rst_n)
        begin
            running_energy = 0;
            energy_clipped = 1'b0;
            cutoff_sq      = '0;
            sums_due.delete();
            fail_count     = 0;
            pending        = 0;
            sums_seen      = 0;
            clips_seen     = 0;
        end
        else
        begin
            if (cfg_we)
                cutoff_sq = cfg_wdata;
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_TABLE_WRITE)
                begin
                    energy_tab[req.table_index] = req.table_value;
                end
                else
                begin
                    if (req.nb_valid)
                    begin
                        dx = longint'(req.nb_x) - longint'(req.point_x);
                        dy = longint'(req.nb_y) - longint'(req.point_y);
                        dz = longint'(req.nb_z) - longint'(req.point_z);
                        r2 = dx * dx + dy * dy + dz * dz;
                        if (r2 <= longint'(cutoff_sq) && r2 < TABLE_DEPTH_DEF)
                        begin
                            next_sum = running_energy + longint'(energy_tab[r2]);
                            if (next_sum > SUM_MAX)
                            begin
                                next_sum       = SUM_MAX;
                                energy_clipped = 1'b1;
                            end
                            else if (next_sum < SUM_MIN)
                            begin
                                next_sum       = SUM_MIN;
                                energy_clipped = 1'b1;
                            end
                            running_energy = next_sum;
                        end
                    end
                    if (req.last)
                    begin
                        want.energy_sum = running_energy[SUM_BITS_DEF-1:0];
                        want.saturated  = energy_clipped;
                        sums_due.insert(sums_due.size(), want);
                        running_energy = 0;
                        energy_clipped = 1'b0;
                    end
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                sums_seen++;
                if (rsp.saturated)
                    clips_seen++;
                if (sums_due.size() == 0)
                begin
                    $error("energy_sum: no query pending, got %0d (saturated %0b)",
                           rsp.energy_sum, rsp.saturated);
                    fail_count++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (rsp.energy_sum !== want.energy_sum)
                    begin
                        $error("energy_sum: expected %0d, got %0d",
                               want.energy_sum, rsp.energy_sum);
                        fail_count++;
                    end
                    if (rsp.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, rsp.saturated);
                        fail_count++;
                    end
                end
            end
            pending = sums_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the lattice pair energy lookup: directed table
// writes and neighbor slots around the cutoff and table edges, runs of the
// largest positive and negative entries, then random queries under
// several cutoff settings and sender/receiver throttling phases
// ----------------------------------------------------------------------------
module tb;
    import lpel_pkg::*;

    typedef struct {
        req_type_t                        kind;
        logic [IDX_BITS-1:0]              idx;
        logic signed [VALUE_BITS-1:0]     value;
        logic signed [COORD_BITS_DEF-1:0] px;
        logic signed [COORD_BITS_DEF-1:0] py;
        logic signed [COORD_BITS_DEF-1:0] pz;
        logic signed [COORD_BITS_DEF-1:0] nx;
        logic signed [COORD_BITS_DEF-1:0] ny;
        logic signed [COORD_BITS_DEF-1:0] nz;
        logic                             nb_valid;
        logic                             last;
    } lattice_req_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CUTOFF_BITS-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int sums_seen;
    int clips_seen;
    int items_sent;
    int gap_pct;
    int stall_pct;
    int cutoff_now;
    bit entry_set [TABLE_DEPTH_DEF];

    lpel_in_if  req_if ();
    lpel_out_if rsp_if ();

    lattice_pair_energy_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    lpel_energy_checker energy_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending),
        .sums_seen  (sums_seen),
        .clips_seen (clips_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #16000000;
        $display("[lattice_pair_energy_lookup_core] ERROR");
        $finish;
    end

    function automatic lattice_req_t random_fields();
        lattice_req_t r;
        r.kind     = req_type_t'($urandom_range(1));
        r.idx      = IDX_BITS'($urandom);
        r.value    = $urandom;
        r.px       = COORD_BITS_DEF'($urandom);
        r.py       = COORD_BITS_DEF'($urandom);
        r.pz       = COORD_BITS_DEF'($urandom);
        r.nx       = COORD_BITS_DEF'($urandom);
        r.ny       = COORD_BITS_DEF'($urandom);
        r.nz       = COORD_BITS_DEF'($urandom);
        r.nb_valid = 1'($urandom_range(1));
        r.last     = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic signed [COORD_BITS_DEF-1:0] near(
        input logic signed [COORD_BITS_DEF-1:0] c,
        input int                               span
    );
        return COORD_BITS_DEF'(int'(c) + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic int dist_sq(input lattice_req_t r);
        int dx;
        int dy;
        int dz;
        dx = int'(r.nx) - int'(r.px);
        dy = int'(r.ny) - int'(r.py);
        dz = int'(r.nz) - int'(r.pz);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic send_request(input lattice_req_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.kind;
        req_if.table_index <= r.idx;
        req_if.table_value <= r.value;
        req_if.point_x     <= r.px;
        req_if.point_y     <= r.py;
        req_if.point_z     <= r.pz;
        req_if.nb_x        <= r.nx;
        req_if.nb_y        <= r.ny;
        req_if.nb_z        <= r.nz;
        req_if.nb_valid    <= r.nb_valid;
        req_if.last        <= r.last;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_entry(input int idx, input logic [VALUE_BITS-1:0] val);
        lattice_req_t r;
        r       = random_fields();
        r.kind  = REQ_TABLE_WRITE;
        r.idx   = IDX_BITS'(idx);
        r.value = val;
        entry_set[idx] = 1'b1;
        send_request(r);
    endtask

    // an entry reachable under the current cutoff is loaded before its first read
    task automatic send_slot(input lattice_req_t r);
        int r2;
        r2 = dist_sq(r);
        if (r.nb_valid && r2 <= cutoff_now && r2 < TABLE_DEPTH_DEF && !entry_set[r2])
            write_entry(r2, $urandom);
        send_request(r);
    endtask

    task automatic slot_at(input int px, input int py, input int pz,
                           input int nx, input int ny, input int nz,
                           input logic present, input logic closing);
        lattice_req_t r;
        r          = random_fields();
        r.kind     = REQ_NEIGHBOR;
        r.px       = COORD_BITS_DEF'(px);
        r.py       = COORD_BITS_DEF'(py);
        r.pz       = COORD_BITS_DEF'(pz);
        r.nx       = COORD_BITS_DEF'(nx);
        r.ny       = COORD_BITS_DEF'(ny);
        r.nz       = COORD_BITS_DEF'(nz);
        r.nb_valid = present;
        r.last     = closing;
        send_slot(r);
    endtask

    task automatic quiesce();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic set_cutoff(input int value);
        quiesce();
        cfg_we     <= 1'b1;
        cfg_wdata  <= CUTOFF_BITS'(value);
        @(negedge clk);
        cfg_we     <= 1'b0;
        cutoff_now = value;
    endtask

    // repeated hits on entry 0 push the 48-bit sum toward a limit
    task automatic drive_to_limit(input logic [VALUE_BITS-1:0] val, input int count,
                                  input logic closing);
        lattice_req_t r;
        write_entry(0, val);
        for (int k = 0; k < count; k++)
        begin
            r          = random_fields();
            r.kind     = REQ_NEIGHBOR;
            r.nx       = r.px;
            r.ny       = r.py;
            r.nz       = r.pz;
            r.nb_valid = 1'b1;
            r.last     = closing && (k == count - 1);
            send_slot(r);
        end
    endtask

    task automatic run_mix(input int n_items);
        int                               start;
        int                               len;
        int                               mode;
        lattice_req_t                     r;
        logic signed [COORD_BITS_DEF-1:0] cx;
        logic signed [COORD_BITS_DEF-1:0] cy;
        logic signed [COORD_BITS_DEF-1:0] cz;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(99) < 12)
            begin
                write_entry($urandom_range(TABLE_DEPTH_DEF - 1), $urandom);
            end
            else
            begin
                len = $urandom_range(8, 1);
                cx  = COORD_BITS_DEF'($urandom);
                cy  = COORD_BITS_DEF'($urandom);
                cz  = COORD_BITS_DEF'($urandom);
                if ($urandom_range(99) < 15)
                begin
                    cx = COORD_BITS_DEF'($urandom_range(1) ? -4096 : 4095);
                    cy = COORD_BITS_DEF'($urandom_range(1) ? -4096 : 4095);
                    cz = COORD_BITS_DEF'($urandom_range(1) ? -4096 : 4095);
                end
                for (int k = 0; k < len; k++)
                begin
                    r      = random_fields();
                    r.kind = REQ_NEIGHBOR;
                    r.px   = cx;
                    r.py   = cy;
                    r.pz   = cz;
                    mode   = $urandom_range(99);
                    if (mode < 15)
                    begin
                        r.nx = near(cx, 2);
                        r.ny = near(cy, 2);
                        r.nz = near(cz, 2);
                    end
                    else if (mode < 85)
                    begin
                        r.nx = near(cx, 37);
                        r.ny = near(cy, 37);
                        r.nz = near(cz, 37);
                    end
                    r.nb_valid = ($urandom_range(99) >= 12);
                    r.last     = (k == len - 1);
                    send_slot(r);
                end
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_TABLE_WRITE;
        req_if.table_index = '0;
        req_if.table_value = '0;
        req_if.point_x     = '0;
        req_if.point_y     = '0;
        req_if.point_z     = '0;
        req_if.nb_x        = '0;
        req_if.nb_y        = '0;
        req_if.nb_z        = '0;
        req_if.nb_valid    = 1'b0;
        req_if.last        = 1'b0;
        items_sent         = 0;
        gap_pct            = 0;
        stall_pct          = 0;
        cutoff_now         = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // cutoff zero: only the zero distance counts
        set_cutoff(0);
        write_entry(0, 32'h7FFF_FFFF);
        write_entry(1, 32'hFFFF_FFFF);
        write_entry(4094, 32'h0001_0000);
        write_entry(4095, 32'h8000_0000);
        slot_at(-4096, -4096, -4096, -4096, -4096, -4096, 1'b1, 1'b1);
        slot_at(4095, 4095, 4095, 4094, 4095, 4095, 1'b1, 1'b1);
        slot_at(-4096, 4095, -4096, 4095, -4096, 4095, 1'b0, 1'b1);

        // full cutoff: entry 4094, distance past the table, far neighbor
        set_cutoff(4095);
        slot_at(0, 0, 0, 63, 11, 2, 1'b1, 1'b0);
        slot_at(0, 0, 0, 64, 0, 0, 1'b1, 1'b0);
        slot_at(-4096, -4096, -4096, 4095, 4095, 4095, 1'b1, 1'b0);
        slot_at(5, -7, 9, 6, -7, 9, 1'b1, 1'b0);
        slot_at(0, 0, 0, 0, 0, 0, 1'b0, 1'b1);

        // runs of the largest entries of both signs
        drive_to_limit(32'h7FFF_FFFF, 40, 1'b0);
        write_entry(1, 32'hFFFF_FFFF);
        slot_at(3, 3, 3, 3, 3, 4, 1'b1, 1'b1);
        drive_to_limit(32'h8000_0000, 40, 1'b1);
        drive_to_limit(32'h8000_0000, 40, 1'b1);

        run_mix(300);

        gap_pct = 53;
        set_cutoff($urandom_range(4094, 1));
        run_mix(300);

        gap_pct   = 0;
        stall_pct = 53;
        set_cutoff($urandom_range(400));
        run_mix(300);

        gap_pct   = 16;
        stall_pct = 16;
        set_cutoff($urandom_range(4095));
        run_mix(300);

        quiesce();
        $display("covered %0d requests and %0d checked energy sums, %0d of them clipped,",
                 items_sent, sums_seen, clips_seen);
        $display("over cutoffs 0, 4095 and random, with and without channel throttling");
        if (fail_count == 0)
            $display("[lattice_pair_energy_lookup_core] OK");
        else
            $display("[lattice_pair_energy_lookup_core] ERROR");
        $finish;
    end

endmodule
